### rtl/rpl_pkg.sv
// ----------------------------------------------------------------------------
// rpl_pkg: shared types and constants for the route prefix lookup
// Item formats, the command passed from the front end to the lookup engine
// and the state encoding of the engine sequencer.
// ----------------------------------------------------------------------------
package rpl_pkg;

	// table geometry
	localparam int ENTRIES  = 16;
	localparam int PORTS    = 4;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ADDR_W   = 32;
	localparam int SLOT_W   = 4;
	localparam int PORT_W   = 2;

	// index of the last table entry, end of a scan
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	// command queue between front end and engine
	localparam int CQ_DEPTH = 4;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	// result queue at the output
	localparam int RQ_DEPTH = 2;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	// operation codes of an input item
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_WRITE  = 1'b1;

	// input item
	typedef struct packed {
		logic              operation;
		logic [SLOT_W-1:0] entry_slot;
		logic              entry_used;
		logic [ADDR_W-1:0] route_destination;
		logic [ADDR_W-1:0] route_netmask;
		logic [ADDR_W-1:0] gateway_address;
		logic [PORT_W-1:0] egress_port;
		logic [ADDR_W-1:0] lookup_address;
	} command_t;

	// result item
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] hit_slot;
		logic [ADDR_W-1:0] hit_netmask;
		logic [ADDR_W-1:0] hit_gateway;
		logic [PORT_W-1:0] hit_port;
		logic              write_done;
	} result_t;

	// classification made by the front end
	typedef enum logic [1:0] {
		CMD_LOOKUP,
		CMD_WRITE,
		CMD_DROP
	} cmd_kind_t;

	// one stored route
	typedef struct packed {
		logic [ADDR_W-1:0] destination;
		logic [ADDR_W-1:0] netmask;
		logic [ADDR_W-1:0] gateway;
		logic [PORT_W-1:0] port;
	} route_t;

	// classified command handed to the engine
	typedef struct packed {
		cmd_kind_t         kind;
		logic [IDX_W-1:0]  slot;
		logic              used;
		route_t            route;
		logic [ADDR_W-1:0] address;
	} work_t;

	// engine sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_LAST,
		BK_REPLY
	} bk_state_t;

endpackage

### rtl/rpl_front.sv
// ----------------------------------------------------------------------------
// rpl_front: input side of the route prefix lookup
// Takes items, sorts them into lookups, valid writes and rejected writes,
// and holds them in a short queue until the lookup engine takes them.
// ----------------------------------------------------------------------------
module rpl_front import rpl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  command_t command,
	output logic     full,
	input  logic     work_pop,
	output logic     work_empty,
	output work_t    work
);

	work_t                cq_mem [CQ_DEPTH];
	logic  [CQ_PTR_W-1:0] wr_ptr_q;
	logic  [CQ_PTR_W-1:0] rd_ptr_q;
	logic  [CQ_CNT_W-1:0] cnt_q;
	logic                 do_push;
	logic                 do_pop;
	work_t                classed;

	// classify: writes outside the table or to a missing port are dropped
	always_comb begin
		classed.slot    = IDX_W'(command.entry_slot);
		classed.used    = command.entry_used;
		classed.route.destination = command.route_destination;
		classed.route.netmask     = command.route_netmask;
		classed.route.gateway     = command.gateway_address;
		classed.route.port        = command.egress_port;
		classed.address = command.lookup_address;
		if (command.operation == OP_LOOKUP) begin
			classed.kind = CMD_LOOKUP;
		end else if ((32'(command.entry_slot) < ENTRIES) &&
				(32'(command.egress_port) < PORTS)) begin
			classed.kind = CMD_WRITE;
		end else begin
			classed.kind = CMD_DROP;
		end
	end

	assign full       = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
	assign work_empty = (cnt_q == '0);
	assign do_push    = push && !full;
	assign do_pop     = work_pop && !work_empty;
	assign work       = cq_mem[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			cq_mem[wr_ptr_q] <= classed;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/rpl_back.sv
// ----------------------------------------------------------------------------
// rpl_back: lookup engine of the route prefix lookup
// Holds the route table, writes entries, scans the table one entry a cycle
// for a lookup and queues the results for the output side.
// ----------------------------------------------------------------------------
module rpl_back import rpl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    work_empty,
	input  work_t   work,
	output logic    work_pop,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	// route table and its valid bits
	route_t               tbl_mem [ENTRIES];
	logic [ENTRIES-1:0]   valid_q;

	// sequencer
	bk_state_t            state_q;
	bk_state_t            state_d;
	logic                 start_lookup;
	logic                 do_write;
	logic                 issue;
	logic                 rq_push;
	cmd_kind_t            kind_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [IDX_W-1:0]     rd_idx_q;

	// compare stage
	logic                 cmp_s1;
	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	route_t               ent_s1;
	logic [ADDR_W-1:0]    net;
	logic                 take;

	// best match so far
	logic                 hit_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [ADDR_W-1:0]    best_mask_q;
	logic [ADDR_W-1:0]    best_gw_q;
	logic [PORT_W-1:0]    best_port_q;

	// result queue
	result_t              rq_mem [RQ_DEPTH];
	logic [RQ_PTR_W-1:0]  rq_wr_q;
	logic [RQ_PTR_W-1:0]  rq_rd_q;
	logic [RQ_CNT_W-1:0]  rq_cnt_q;
	logic                 rq_pop;
	result_t              res_d;

	// next state and control
	always_comb begin
		state_d      = state_q;
		work_pop     = 1'b0;
		start_lookup = 1'b0;
		do_write     = 1'b0;
		issue        = 1'b0;
		rq_push      = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!work_empty) begin
					work_pop = 1'b1;
					if (work.kind == CMD_LOOKUP) begin
						start_lookup = 1'b1;
						state_d      = BK_SCAN;
					end else begin
						do_write = (work.kind == CMD_WRITE);
						state_d  = BK_REPLY;
					end
				end
			end
			BK_SCAN: begin
				issue = 1'b1;
				if (rd_idx_q == LAST_IDX) begin
					state_d = BK_LAST;
				end
			end
			BK_LAST: begin
				state_d = BK_REPLY;
			end
			BK_REPLY: begin
				if (rq_cnt_q != RQ_CNT_W'(RQ_DEPTH)) begin
					rq_push = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// match test on the entry read last cycle
	assign net  = addr_q & ent_s1.netmask;
	assign take = cmp_s1 && vld_s1 &&
		((net == ent_s1.destination) || (net == '0)) &&
		(!hit_q || (ent_s1.netmask >= best_mask_q));

	// result assembly; winner fields stay zero when nothing matched
	always_comb begin
		res_d             = '0;
		if (kind_q == CMD_LOOKUP) begin
			res_d.found       = hit_q;
			res_d.hit_slot    = SLOT_W'(best_idx_q);
			res_d.hit_netmask = best_mask_q;
			res_d.hit_gateway = best_gw_q;
			res_d.hit_port    = best_port_q;
		end else begin
			res_d.write_done  = (kind_q == CMD_WRITE);
		end
	end

	// table storage, registered read
	always_ff @(posedge clk) begin
		if (do_write) begin
			tbl_mem[work.slot] <= work.route;
		end
		if (issue) begin
			ent_s1 <= tbl_mem[rd_idx_q];
			idx_s1 <= rd_idx_q;
		end
	end

	// command payload and best-match payload
	always_ff @(posedge clk) begin
		if (work_pop) begin
			kind_q <= work.kind;
			addr_q <= work.address;
		end
		if (start_lookup) begin
			best_idx_q  <= '0;
			best_mask_q <= '0;
			best_gw_q   <= '0;
			best_port_q <= '0;
		end else if (take) begin
			best_idx_q  <= idx_s1;
			best_mask_q <= ent_s1.netmask;
			best_gw_q   <= ent_s1.gateway;
			best_port_q <= ent_s1.port;
		end
		if (rq_push) begin
			rq_mem[rq_wr_q] <= res_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			valid_q  <= '0;
			rd_idx_q <= '0;
			cmp_s1   <= 1'b0;
			vld_s1   <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_write) begin
				valid_q[work.slot] <= work.used;
			end
			if (start_lookup) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			cmp_s1 <= issue;
			vld_s1 <= issue && valid_q[rd_idx_q];
			if (start_lookup) begin
				hit_q <= 1'b0;
			end else if (take) begin
				hit_q <= 1'b1;
			end
		end
	end

	// result queue pointers and fill count
	assign empty  = (rq_cnt_q == '0);
	assign rq_pop = pop && !empty;
	assign result = rq_mem[rq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (rq_push) begin
				rq_wr_q <= rq_wr_q + 1'b1;
			end
			if (rq_pop) begin
				rq_rd_q <= rq_rd_q + 1'b1;
			end
			if (rq_push && !rq_pop) begin
				rq_cnt_q <= rq_cnt_q + 1'b1;
			end else if (rq_pop && !rq_push) begin
				rq_cnt_q <= rq_cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/route_prefix_lookup.sv
// ----------------------------------------------------------------------------
// route_prefix_lookup: routing table with longest-mask lookup
// Input items either write one route entry or look up an address; each item
// gives exactly one result item, in order.
//
// Input channel: queue style. An item is taken on a clock edge with push
// high and full low. A four-deep command queue sits behind it, so items are
// taken while the engine is busy until that queue fills.
// Result channel: queue style. The oldest result sits on result while empty
// is low and leaves on an edge with pop high. Two results can wait; when
// both slots are taken the engine holds its finished result and stops.
// Timing: a lookup reads the table one entry per cycle through a single
// registered read port. The engine takes one item from the command queue
// when idle; a lookup steps through BK_SCAN, BK_LAST and BK_REPLY, a write
// or a rejected write goes straight to BK_REPLY. The engine takes no new
// item until its result has entered the result queue.
// Reset (arst_n low) empties both queues and marks every table entry
// invalid; entry data is not cleared and is only matched while valid.
// ----------------------------------------------------------------------------
module route_prefix_lookup import rpl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  command_t command,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output result_t  result
);

	logic  work_pop;
	logic  work_empty;
	work_t work;

	// front end: accept and classify
	rpl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.command    (command),
		.full       (full),
		.work_pop   (work_pop),
		.work_empty (work_empty),
		.work       (work)
	);

	// engine: table, scan and result queue
	rpl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_empty (work_empty),
		.work       (work),
		.work_pop   (work_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

endmodule
